>>> sv/lane_marking_midpoint_finder_macros.svh
// Assertion macros shared by the lane marking midpoint finder RTL.
`ifndef LANE_MARKING_MIDPOINT_FINDER_MACROS_SVH
`define LANE_MARKING_MIDPOINT_FINDER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold on every clock edge outside reset.
`define LMMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lmmf assertion failed");
// Condition in one cycle implies a result in the next.
`define LMMF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lmmf assertion failed");
`else
`define LMMF_ASSERT(lbl, prop)
`define LMMF_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> sv/lmmf_pkg.sv
// Types and constants of the lane marking midpoint finder.
package lmmf_pkg;

  localparam int X_W       = 11;
  localparam int GAP_W     = 7;
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [PIX_W-1:0] BRIGHT_LEVEL = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_X_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_X_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_Y_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_Y_HIGH = 3'd5;

  // Reset values
  localparam logic [GAP_W-1:0] GAP_MIN_RST = 7'd10;
  localparam logic [GAP_W-1:0] GAP_MAX_RST = 7'd40;

  typedef struct packed {
    logic [GAP_W-1:0] gap_min;
    logic [GAP_W-1:0] gap_max;
    logic [X_W-1:0]   ignore_x_low;
    logic [X_W-1:0]   ignore_x_high;
    logic [X_W-1:0]   ignore_y_low;
    logic [X_W-1:0]   ignore_y_high;
  } cfg_t;

  // Midpoint candidate leaving the pairing stage
  typedef struct packed {
    logic           hit;
    logic [X_W-1:0] mid_x;
    logic [X_W-1:0] mid_y;
  } cand_t;

endpackage

>>> sv/lmmf_cfg_regs.sv
// Configuration register file of the lane marking midpoint finder.
module lmmf_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lmmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmmf_pkg::X_W-1:0]       cfg_data,
  output lmmf_pkg::cfg_t                 cfg
);

  // Writes are never stalled
  assign cfg_ready = 1'b1;

  // Register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_min       <= lmmf_pkg::GAP_MIN_RST;
      cfg.gap_max       <= lmmf_pkg::GAP_MAX_RST;
      cfg.ignore_x_low  <= '0;
      cfg.ignore_x_high <= '0;
      cfg.ignore_y_low  <= '0;
      cfg.ignore_y_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lmmf_pkg::REG_GAP_MIN:       cfg.gap_min <= cfg_data[lmmf_pkg::GAP_W-1:0];
        lmmf_pkg::REG_GAP_MAX:       cfg.gap_max <= cfg_data[lmmf_pkg::GAP_W-1:0];
        lmmf_pkg::REG_IGNORE_X_LOW:  cfg.ignore_x_low  <= cfg_data;
        lmmf_pkg::REG_IGNORE_X_HIGH: cfg.ignore_x_high <= cfg_data;
        lmmf_pkg::REG_IGNORE_Y_LOW:  cfg.ignore_y_low  <= cfg_data;
        lmmf_pkg::REG_IGNORE_Y_HIGH: cfg.ignore_y_high <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/lmmf_history_ram.sv
// One-bit brightness history memory with a registered read port.
module lmmf_history_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_data
);

  logic mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/lmmf_pair_stage.sv
// Column tracking, edge pairing and midpoint qualification.
`include "lane_marking_midpoint_finder_macros.svh"

module lmmf_pair_stage #(
  parameter int ROW_WIDTH     = 2048,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       edge_pixel,
  input  logic [lmmf_pkg::PIX_W-1:0] warped_pixel,
  input  logic [lmmf_pkg::X_W-1:0]   row_y,
  input  logic                       row_start,
  input  lmmf_pkg::cfg_t             cfg,
  output logic [$clog2(HISTORY_DEPTH)-1:0] hist_wr_addr,
  output logic                       hist_wr_data,
  output logic [$clog2(HISTORY_DEPTH)-1:0] hist_rd_addr,
  output lmmf_pkg::cand_t            cand
);

  localparam int CW   = $clog2(ROW_WIDTH);
  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int XW   = (CW > lmmf_pkg::X_W) ? CW : lmmf_pkg::X_W;
  localparam int GW   = (CW > lmmf_pkg::GAP_W) ? CW : lmmf_pkg::GAP_W;
  localparam logic [CW-1:0] COL_LAST = CW'(ROW_WIDTH - 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW-1:0] PTR_WRAP = AW'(HISTORY_DEPTH);

  logic [CW-1:0] column;
  logic [CW-1:0] prev_edge_x;
  logic          have_prev_edge;
  logic [AW-1:0] hist_ptr;

  logic [CW-1:0] col_eff;
  logic [AW-1:0] ptr_eff;
  logic          prev_ok;
  logic [CW-1:0] gap;
  logic [CW-1:0] half_gap;
  logic [CW-1:0] mid;
  logic [CW-1:0] back;
  logic [AW-1:0] back_a;
  logic [XW-1:0] mid_w;
  logic          gap_ok;
  logic          back_ok;
  logic          in_window;
  logic          col_wrap;

  // Row start restarts the column before the pixel is handled
  always_comb begin
    col_eff  = row_start ? '0 : column;
    ptr_eff  = row_start ? '0 : hist_ptr;
    prev_ok  = have_prev_edge && !row_start;
    col_wrap = (col_eff == COL_LAST);
  end

  // Spacing, midpoint and distance back into the history
  always_comb begin
    gap      = col_eff - prev_edge_x;
    half_gap = gap >> 1;
    mid      = prev_edge_x + half_gap;
    back     = gap - half_gap;
    back_a   = back[AW-1:0];
    mid_w    = XW'(mid);
    gap_ok   = (GW'(gap) >= GW'(cfg.gap_min)) && (GW'(gap) <= GW'(cfg.gap_max));
    back_ok  = (32'(back) < 32'(HISTORY_DEPTH));
    in_window = (mid_w > XW'(cfg.ignore_x_low)) && (mid_w <= XW'(cfg.ignore_x_high)) &&
                (row_y > cfg.ignore_y_low) && (row_y <= cfg.ignore_y_high);
  end

  // History ports: current column written, midpoint column read
  always_comb begin
    hist_wr_addr = ptr_eff;
    hist_wr_data = (warped_pixel == lmmf_pkg::BRIGHT_LEVEL);
    if (ptr_eff >= back_a) begin
      hist_rd_addr = ptr_eff - back_a;
    end else begin
      hist_rd_addr = ptr_eff + PTR_WRAP - back_a;
    end
  end

  // Candidate, still subject to the brightness lookup
  always_comb begin
    cand.hit   = edge_pixel && prev_ok && (prev_edge_x < col_eff) &&
                 gap_ok && back_ok && !in_window;
    cand.mid_x = mid_w[lmmf_pkg::X_W-1:0];
    cand.mid_y = row_y;
  end

  // Column, history pointer and last edge tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      hist_ptr       <= '0;
      prev_edge_x    <= '0;
      have_prev_edge <= 1'b0;
    end else if (accept) begin
      if (edge_pixel) begin
        prev_edge_x <= col_eff;
      end
      if (col_wrap) begin
        column         <= '0;
        hist_ptr       <= '0;
        have_prev_edge <= 1'b0;
      end else begin
        column         <= col_eff + 1'b1;
        hist_ptr       <= (ptr_eff == PTR_LAST) ? '0 : ptr_eff + 1'b1;
        have_prev_edge <= edge_pixel || prev_ok;
      end
    end
  end

  `LMMF_ASSERT(a_prev_edge_behind, !have_prev_edge || (prev_edge_x < column))
  `LMMF_ASSERT(a_hist_ptr_range, 32'(hist_ptr) < 32'(HISTORY_DEPTH))

endmodule

>>> sv/lane_marking_midpoint_finder.sv
// Top level of the lane marking midpoint finder.
// Takes one pixel per clock (edge bit, warped intensity, row y, row start) and pairs each
// edge pixel with the previous edge of the same row; a pair whose spacing lies in
// [gap_min, gap_max] yields the midpoint, kept only outside the ignore window, within
// HISTORY_DEPTH columns of the current pixel, and where the warped pixel at the midpoint
// was 255. Throughput is one pixel per cycle while the input is not stalled. The edge that
// takes a pixel also registers its midpoint candidate and the brightness history read; the
// output register then loads from the lookup stage whenever out_valid is low or out_ready is
// high. The input stalls only while both the lookup stage and the output register hold a
// midpoint and out_ready is low. No clearing pass is needed after reset.
// Configuration writes are never stalled and belong to idle periods.
`include "lane_marking_midpoint_finder_macros.svh"

module lane_marking_midpoint_finder #(
  parameter int ROW_WIDTH     = 2048,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           edge_pixel,
  input  logic [lmmf_pkg::PIX_W-1:0]     warped_pixel,
  input  logic [lmmf_pkg::X_W-1:0]       row_y,
  input  logic                           row_start,
  // midpoint output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lmmf_pkg::X_W-1:0]       mid_x,
  output logic [lmmf_pkg::X_W-1:0]       mid_y,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lmmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmmf_pkg::X_W-1:0]       cfg_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  lmmf_pkg::cfg_t  cfg;
  lmmf_pkg::cand_t cand;

  logic          in_fire;
  logic          out_load;
  logic [AW-1:0] hist_wr_addr;
  logic          hist_wr_data;
  logic [AW-1:0] hist_rd_addr;
  logic          hist_bright;

  // Lookup stage registers
  logic                     s1_valid;
  logic [lmmf_pkg::X_W-1:0] s1_mid_x;
  logic [lmmf_pkg::X_W-1:0] s1_mid_y;

  lmmf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmmf_pair_stage #(
    .ROW_WIDTH     (ROW_WIDTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_pair (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_fire),
    .edge_pixel   (edge_pixel),
    .warped_pixel (warped_pixel),
    .row_y        (row_y),
    .row_start    (row_start),
    .cfg          (cfg),
    .hist_wr_addr (hist_wr_addr),
    .hist_wr_data (hist_wr_data),
    .hist_rd_addr (hist_rd_addr),
    .cand         (cand)
  );

  lmmf_history_ram #(
    .DEPTH  (HISTORY_DEPTH),
    .ADDR_W (AW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (hist_wr_addr),
    .wr_data (hist_wr_data),
    .rd_en   (in_fire),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_bright)
  );

  // Pipeline flow control
  assign out_load = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_load;
  assign in_fire  = in_valid && in_ready;

  // Lookup stage: candidate waits for the history read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= cand.hit;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mid_x <= cand.mid_x;
      s1_mid_y <= cand.mid_y;
    end
  end

  // Output register: keep only bright midpoints
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid && hist_bright;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mid_x <= s1_mid_x;
      mid_y <= s1_mid_y;
    end
  end

  `LMMF_ASSERT_NEXT(a_cand_captured, in_fire && cand.hit, s1_valid)
  `LMMF_ASSERT_NEXT(a_pending_kept, s1_valid && out_valid && !out_ready, s1_valid)
  `LMMF_ASSERT(a_result_from_lookup, !$rose(out_valid) || $past(s1_valid && hist_bright))

endmodule

>>> tb/lane_marking_midpoint_finder_test.sv
// Self-checking testbench for the lane marking midpoint finder.
`timescale 1ns / 100ps

module lane_marking_midpoint_finder_test;

  localparam int ROW_PIXELS   = 2048;
  localparam int BRIGHT_DEPTH = 64;
  localparam int ROW_BUF      = 2200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 500;

  // Indexes that decode to no register
  localparam logic [lmmf_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [lmmf_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [lmmf_pkg::X_W-1:0] x;
    logic [lmmf_pkg::X_W-1:0] y;
  } midpoint_t;

  // Tracks the pixel stream, predicts the midpoints and checks what comes out
  class midpoint_tracker;
    logic [lmmf_pkg::GAP_W-1:0] gap_min;
    logic [lmmf_pkg::GAP_W-1:0] gap_max;
    logic [lmmf_pkg::X_W-1:0]   win_x_lo;
    logic [lmmf_pkg::X_W-1:0]   win_x_hi;
    logic [lmmf_pkg::X_W-1:0]   win_y_lo;
    logic [lmmf_pkg::X_W-1:0]   win_y_hi;
    int                         column;
    int                         last_edge_x;
    bit                         have_edge;
    bit                         bright [BRIGHT_DEPTH];
    midpoint_t                  pending_midpoints [$];
    int                         errors;

    function new();
      gap_min     = lmmf_pkg::GAP_MIN_RST;
      gap_max     = lmmf_pkg::GAP_MAX_RST;
      win_x_lo    = '0;
      win_x_hi    = '0;
      win_y_lo    = '0;
      win_y_hi    = '0;
      column      = 0;
      last_edge_x = 0;
      have_edge   = 0;
      errors      = 0;
      foreach (bright[i]) bright[i] = 0;
    endfunction

    function void write_reg(logic [lmmf_pkg::CFG_IDX_W-1:0] idx,
                            logic [lmmf_pkg::X_W-1:0] data);
      case (idx)
        lmmf_pkg::REG_GAP_MIN:       gap_min  = data[lmmf_pkg::GAP_W-1:0];
        lmmf_pkg::REG_GAP_MAX:       gap_max  = data[lmmf_pkg::GAP_W-1:0];
        lmmf_pkg::REG_IGNORE_X_LOW:  win_x_lo = data;
        lmmf_pkg::REG_IGNORE_X_HIGH: win_x_hi = data;
        lmmf_pkg::REG_IGNORE_Y_LOW:  win_y_lo = data;
        lmmf_pkg::REG_IGNORE_Y_HIGH: win_y_hi = data;
        default: ;
      endcase
    endfunction

    // One accepted pixel transaction; queues the midpoint it yields, if any
    function void take_pixel(bit edge_bit, logic [lmmf_pkg::PIX_W-1:0] warped,
                             logic [lmmf_pkg::X_W-1:0] y, bit start);
      int        gap;
      int        mid;
      int        back;
      bit        masked;
      midpoint_t hit;
      if (start) begin
        column    = 0;
        have_edge = 0;
      end
      bright[column % BRIGHT_DEPTH] = (warped == lmmf_pkg::BRIGHT_LEVEL);
      if (edge_bit) begin
        if (have_edge && last_edge_x < column) begin
          gap = column - last_edge_x;
          if (gap >= gap_min && gap <= gap_max) begin
            mid    = last_edge_x + gap / 2;
            back   = column - mid;
            masked = mid > win_x_lo && mid <= win_x_hi && y > win_y_lo && y <= win_y_hi;
            if (!masked && back < BRIGHT_DEPTH && bright[mid % BRIGHT_DEPTH]) begin
              hit.x = mid[lmmf_pkg::X_W-1:0];
              hit.y = y;
              pending_midpoints = {pending_midpoints, hit};
            end
          end
        end
        last_edge_x = column;
        have_edge   = 1;
      end
      // running off the row end acts like a new row
      if (column + 1 >= ROW_PIXELS) begin
        column    = 0;
        have_edge = 0;
      end else begin
        column = column + 1;
      end
    endfunction

    // One accepted result transaction against the oldest prediction
    function void match_midpoint(logic [lmmf_pkg::X_W-1:0] x, logic [lmmf_pkg::X_W-1:0] y);
      midpoint_t exp_pt;
      if (pending_midpoints.size() == 0) begin
        $display("%0t: unexpected midpoint, expected none, actual x=%0d y=%0d", $time, x, y);
        errors++;
        return;
      end
      exp_pt = pending_midpoints.pop_front();
      if (x !== exp_pt.x) begin
        $display("%0t: mid_x mismatch, expected %0d, actual %0d", $time, exp_pt.x, x);
        errors++;
      end
      if (y !== exp_pt.y) begin
        $display("%0t: mid_y mismatch, expected %0d, actual %0d", $time, exp_pt.y, y);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic                           edge_pixel;
  logic [lmmf_pkg::PIX_W-1:0]     warped_pixel;
  logic [lmmf_pkg::X_W-1:0]       row_y;
  logic                           row_start;
  logic                           out_valid;
  logic                           out_ready;
  logic [lmmf_pkg::X_W-1:0]       mid_x;
  logic [lmmf_pkg::X_W-1:0]       mid_y;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [lmmf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lmmf_pkg::X_W-1:0]       cfg_data;

  midpoint_tracker            track;
  bit                         gaps_on;
  bit                         hold_off_req;
  int                         hold_left;
  int                         cycle_count;
  bit                         row_edges [ROW_BUF];
  logic [lmmf_pkg::PIX_W-1:0] row_warps [ROW_BUF];

  lane_marking_midpoint_finder #(
    .ROW_WIDTH     (ROW_PIXELS),
    .HISTORY_DEPTH (BRIGHT_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .edge_pixel   (edge_pixel),
    .warped_pixel (warped_pixel),
    .row_y        (row_y),
    .row_start    (row_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mid_x        (mid_x),
    .mid_y        (mid_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run limit reached, %0d midpoints still pending", $time,
               track.pending_midpoints.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < 17) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) track.match_midpoint(mid_x, mid_y);
    end
  end

  // Offers one pixel; starts and ends at a falling edge, leaves in_valid high
  task send_pixel(bit edge_bit, logic [lmmf_pkg::PIX_W-1:0] warped,
                  logic [lmmf_pkg::X_W-1:0] y, bit start);
    while (gaps_on && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    edge_pixel   <= edge_bit;
    warped_pixel <= warped;
    row_y        <= y;
    row_start    <= start;
    do @(posedge clk); while (!in_ready);
    track.take_pixel(edge_bit, warped, y, start);
    @(negedge clk);
  endtask

  // One configuration transaction; leaves cfg_valid high
  task cfg_write(logic [lmmf_pkg::CFG_IDX_W-1:0] idx, logic [lmmf_pkg::X_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    track.write_reg(idx, data);
    @(negedge clk);
  endtask

  task set_config(logic [lmmf_pkg::X_W-1:0] gmin, logic [lmmf_pkg::X_W-1:0] gmax,
                  logic [lmmf_pkg::X_W-1:0] xl, logic [lmmf_pkg::X_W-1:0] xh,
                  logic [lmmf_pkg::X_W-1:0] yl, logic [lmmf_pkg::X_W-1:0] yh);
    cfg_write(lmmf_pkg::REG_GAP_MIN, gmin);
    cfg_write(lmmf_pkg::REG_GAP_MAX, gmax);
    cfg_write(lmmf_pkg::REG_IGNORE_X_LOW, xl);
    cfg_write(lmmf_pkg::REG_IGNORE_X_HIGH, xh);
    cfg_write(lmmf_pkg::REG_IGNORE_Y_LOW, yl);
    cfg_write(lmmf_pkg::REG_IGNORE_Y_HIGH, yh);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering pixels and let every pending midpoint come out
  task wait_idle();
    in_valid <= 1'b0;
    while (track.pending_midpoints.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // One row: edge pairs mostly spaced inside the gap range, bright midpoints
  task send_row(int len, logic [lmmf_pkg::X_W-1:0] base_y, bit y_jitter, bit noise,
                bit first_start);
    int pos;
    int sp;
    int mid;
    int lo;
    int hi;
    logic [lmmf_pkg::X_W-1:0] y;
    for (int c = 0; c < len; c++) begin
      row_edges[c] = 0;
      row_warps[c] = ($urandom_range(0, 99) < 40) ? lmmf_pkg::BRIGHT_LEVEL :
                     $urandom_range(0, 255);
    end
    if (noise) begin
      for (int c = 0; c < len; c++) row_edges[c] = ($urandom_range(0, 4) == 0);
    end else begin
      lo  = (track.gap_min < 1) ? 1 : track.gap_min;
      hi  = track.gap_max;
      pos = $urandom_range(0, 5);
      while (pos < len) begin
        row_edges[pos] = 1;
        if (lo <= hi && $urandom_range(0, 99) < 75) sp = $urandom_range(lo, hi);
        else sp = $urandom_range(1, 130);
        mid = pos + sp / 2;
        if (mid < len && $urandom_range(0, 99) < 85) row_warps[mid] = lmmf_pkg::BRIGHT_LEVEL;
        pos += sp;
      end
    end
    for (int c = 0; c < len; c++) begin
      y = y_jitter ? $urandom_range(0, 2047) : base_y;
      send_pixel(row_edges[c], row_warps[c], y, c == 0 && first_start);
    end
  endtask

  // Random rows, mostly short, until about n pixels went in
  task run_rows(int n, int y_span, int start_pct);
    int count;
    int len;
    logic [lmmf_pkg::X_W-1:0] y;
    count = 0;
    while (count < n) begin
      len = ($urandom_range(0, 99) < 5) ? $urandom_range(150, 400) : $urandom_range(8, 150);
      y   = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 2047) : $urandom_range(0, y_span);
      send_row(len, y, $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 10,
               $urandom_range(0, 99) < start_pct);
      count += len;
    end
  endtask

  initial begin
    int gmin;
    int xl;
    int yl;
    track        = new();
    cycle_count  = 0;
    gaps_on      = 1;
    hold_off_req = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    edge_pixel   = 1'b0;
    warped_pixel = '0;
    row_y        = '0;
    row_start    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = lmmf_pkg::REG_GAP_MIN;
    cfg_data     = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings, bottom row, pair of spacing 10 with a bright midpoint
    for (int c = 0; c <= 10; c++)
      send_pixel(c == 0 || c == 10, (c == 5) ? 8'd255 : (c[0] ? 8'd254 : 8'd0),
                 11'd2047, c == 0);
    // Directed: top row, too close a pair, then a pair whose midpoint is 254
    for (int c = 0; c <= 12; c++)
      send_pixel(c == 0 || c == 1 || c == 12, (c == 6) ? 8'd254 : 8'd255, 11'd0, c == 0);
    wait_idle();

    // Reset settings, random rows with row starts
    run_rows(150, 15, 92);
    wait_idle();

    // From here on no row start: the column runs on to the row end and wraps

    // Gap range 0 to 126, ignore window in the upper left
    set_config(0, 126, 20, 200, 2, 9);
    run_rows(250, 12, 0);
    wait_idle();

    // Single gap value, empty window, no idling at all
    set_config(5, 5, 2047, 0, 2047, 0);
    gaps_on = 0;
    run_rows(200, 15, 0);
    wait_idle();
    gaps_on = 1;

    // Inverted gap bounds, window over nearly the whole image
    set_config(30, 10, 0, 2047, 0, 2047);
    run_rows(100, 15, 0);
    wait_idle();

    // Upper data bits beyond the gap fields, spare indexes, long output hold-off
    set_config(11'h781, 11'h7FE, 0, 2047, 2046, 2047);
    cfg_write(REG_SPARE_6, 11'h7FF);
    cfg_write(REG_SPARE_7, 11'h555);
    cfg_valid    <= 1'b0;
    hold_off_req = 1;
    run_rows(250, 2047, 0);
    wait_idle();

    // Random settings
    repeat (3) begin
      gmin = $urandom_range(0, 40);
      xl   = $urandom_range(0, 100);
      yl   = $urandom_range(0, 8);
      set_config(gmin, ($urandom_range(0, 99) < 80) ? $urandom_range(gmin, 126) :
                 $urandom_range(0, 126), xl, xl + $urandom_range(0, 100), yl,
                 yl + $urandom_range(0, 8));
      run_rows(80, 15, 0);
      wait_idle();
    end

    // Run past the row end: the column wraps without a row start
    set_config(2, 60, 0, 0, 0, 0);
    send_row(ROW_PIXELS + 30 - track.column, $urandom_range(0, 2047), 0, 0, 0);
    wait_idle();

    repeat (20) @(negedge clk);
    if (track.pending_midpoints.size() != 0) begin
      $display("%0t: %0d midpoints never came out", $time, track.pending_midpoints.size());
      track.errors++;
    end
    if (track.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
